@@ hdl/spq_pkg.sv @@
// Shared types and constants for the stable priority queue.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package spq_pkg;

   // Number of cells in the chain, and width of the entry counter (0..QUEUE_DEPTH).
   localparam int QUEUE_DEPTH = 64;
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

   // Fixed payload widths.
   localparam int PRIO_W  = 16;
   localparam int DEPTH_W = 8;
   localparam int TAG_W   = 16;
   localparam int OCC_W   = 7;

   // Command codes.
   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_DEQUEUE = 1'b1;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_ENQUEUED = 2'd0,
      ST_RETURNED = 2'd1,
      ST_NO_ENTRY = 2'd2,
      ST_FULL     = 2'd3
   } spq_status_type;

   // One stored entry.
   typedef struct packed {
      logic signed [PRIO_W-1:0] prio;
      logic [DEPTH_W-1:0]       depth;
      logic [TAG_W-1:0]         item;
      logic [TAG_W-1:0]         parent;
   } spq_entry_type;

   // Operation broadcast to every cell in a cycle.
   typedef struct packed {
      logic enq;
      logic deq;
   } spq_op_type;

endpackage

`default_nettype wire

@@ hdl/spq_if.sv @@
// Valid/ready channel interfaces for the request and response sides.
// Depends on spq_pkg for the payload widths.
`default_nettype none

interface spq_req_if;
   import spq_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     command;
   logic signed [PRIO_W-1:0] priority_req;
   logic [DEPTH_W-1:0]       crawl_depth;
   logic [TAG_W-1:0]         item_tag;
   logic [TAG_W-1:0]         parent_tag;
   logic                     halt;

   modport source (output valid, command, priority_req, crawl_depth, item_tag,
                   parent_tag, halt, input ready);
   modport sink   (input valid, command, priority_req, crawl_depth, item_tag,
                   parent_tag, halt, output ready);
endinterface

interface spq_rsp_if;
   import spq_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [1:0]               status;
   logic signed [PRIO_W-1:0] out_priority;
   logic [DEPTH_W-1:0]       out_depth;
   logic [TAG_W-1:0]         out_item_tag;
   logic [TAG_W-1:0]         out_parent_tag;
   logic [OCC_W-1:0]         occupancy;

   modport source (output valid, status, out_priority, out_depth, out_item_tag,
                   out_parent_tag, occupancy, input ready);
   modport sink   (input valid, status, out_priority, out_depth, out_item_tag,
                   out_parent_tag, occupancy, output ready);
endinterface

`default_nettype wire

@@ hdl/stable_priority_queue_top.sv @@
// Stable priority queue: a row of spq_cell entries kept sorted by priority,
// with the entry counter and response register. Uses spq_pkg, spq_if, spq_cell.
`default_nettype none

// The queue holds up to QUEUE_DEPTH entries in a chain of cells kept in
// descending priority order, equal priorities in arrival order. Every request
// beat (enqueue or dequeue) is handled at once: all cells compare their
// priority with the incoming one in parallel and shift by one place at the
// same clock edge, so one request is accepted per cycle while the response
// side keeps up, and its response beat appears on the next cycle from the
// response register. A request is taken whenever the response register is
// empty or is being drained in the same cycle. Each request yields exactly
// one response beat. Cell contents are not cleared by reset; only the entry
// counter and valid flag are, and the counter alone marks occupied cells.

module stable_priority_queue_top import spq_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   spq_req_if.sink    req_chan,
   spq_rsp_if.source  rsp_chan
);

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;

   logic                     rsp_valid_ff;
   spq_status_type           rsp_status_ff;
   spq_status_type           rsp_status_in;
   spq_entry_type            rsp_entry_ff;
   spq_entry_type            rsp_entry_in;
   logic [OCC_W-1:0]         rsp_occ_ff;

   logic          accept;
   logic          is_full;
   logic          is_empty;
   spq_op_type    op;
   spq_entry_type new_entry;
   spq_entry_type cell_entry [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] cell_keep;

   // Handshake: take a request when the response slot is empty or frees this cycle.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign is_full  = (count_ff == COUNT_W'(QUEUE_DEPTH));
   assign is_empty = (count_ff == '0);

   assign new_entry.prio   = req_chan.priority_req;
   assign new_entry.depth  = req_chan.crawl_depth;
   assign new_entry.item   = req_chan.item_tag;
   assign new_entry.parent = req_chan.parent_tag;

   // Decode the request into a chain operation and a status.
   always_comb begin
      op            = '0;
      rsp_status_in = ST_NO_ENTRY;
      rsp_entry_in  = '0;
      count_in      = count_ff;
      if (req_chan.command == CMD_ENQUEUE) begin
         if (is_full) begin
            rsp_status_in = ST_FULL;
         end else begin
            rsp_status_in = ST_ENQUEUED;
            op.enq        = accept;
            count_in      = count_ff + COUNT_W'(1);
         end
      end else begin
         if (req_chan.halt || is_empty) begin
            rsp_status_in = ST_NO_ENTRY;
         end else begin
            rsp_status_in = ST_RETURNED;
            rsp_entry_in  = cell_entry[0];
            op.deq        = accept;
            count_in      = count_ff - COUNT_W'(1);
         end
      end
   end

   // Chain of cells; the head is cell 0.
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic keep_left;
      spq_entry_type left_entry;
      spq_entry_type right_entry;

      if (i == 0) begin : g_head
         assign keep_left  = 1'b1;
         assign left_entry = new_entry;
      end else begin : g_body
         assign keep_left  = cell_keep[i-1];
         assign left_entry = cell_entry[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_entry = new_entry;
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .op          (op),
         .valid       (count_ff > COUNT_W'(i)),
         .keep_left   (keep_left),
         .new_entry   (new_entry),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .keep        (cell_keep[i]),
         .entry       (cell_entry[i])
      );
   end

   // Entry counter and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_entry_ff  <= rsp_entry_in;
         rsp_occ_ff    <= OCC_W'(count_in);
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.out_priority   = rsp_entry_ff.prio;
   assign rsp_chan.out_depth      = rsp_entry_ff.depth;
   assign rsp_chan.out_item_tag   = rsp_entry_ff.item;
   assign rsp_chan.out_parent_tag = rsp_entry_ff.parent;
   assign rsp_chan.occupancy      = rsp_occ_ff;

endmodule

`default_nettype wire

@@ hdl/spq_cell.sv @@
// One cell of the sorted shift chain: holds a single entry and decides each
// cycle whether to hold, take the new entry, or take a neighbor's. Uses spq_pkg.
`default_nettype none

module spq_cell import spq_pkg::*; (
   input  wire logic          clock,
   input  wire spq_op_type    op,
   input  wire logic          valid,
   input  wire logic          keep_left,
   input  wire spq_entry_type new_entry,
   input  wire spq_entry_type left_entry,
   input  wire spq_entry_type right_entry,
   output logic               keep,
   output spq_entry_type      entry
);

   spq_entry_type entry_ff;
   spq_entry_type entry_in;

   // An occupied cell stays in front of the new entry when its priority is
   // equal or higher; equal priorities therefore keep arrival order.
   assign keep  = valid && (entry_ff.prio >= new_entry.prio);
   assign entry = entry_ff;

   // Insertion point is the first cell that does not keep; cells behind it
   // shift one place toward the tail. A dequeue shifts the chain to the head.
   always_comb begin
      entry_in = entry_ff;
      if (op.enq) begin
         if (!keep) begin
            entry_in = keep_left ? new_entry : left_entry;
         end
      end else if (op.deq) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

@@ hdl/spq_checker.sv @@
// Port-level checks for the stable priority queue, bound to the top level.
// Uses spq_pkg; sees only the top-level channel signals.
`default_nettype none

module spq_checker import spq_pkg::*; (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic [1:0]         status,
   input wire logic [PRIO_W-1:0]  out_priority,
   input wire logic [DEPTH_W-1:0] out_depth,
   input wire logic [TAG_W-1:0]   out_item_tag,
   input wire logic [TAG_W-1:0]   out_parent_tag,
   input wire logic [OCC_W-1:0]   occupancy
);

   // Every accepted request beat produces a response beat on the next cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("request beat not followed by a response beat");

   // Entry fields are zero unless an entry is returned.
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && status != ST_RETURNED) |->
         (out_priority == '0 && out_depth == '0 &&
          out_item_tag == '0 && out_parent_tag == '0))
      else $error("entry fields nonzero without a returned entry");

   // A dropped enqueue is reported only with a full queue.
   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && status == ST_FULL) |-> (occupancy == OCC_W'(QUEUE_DEPTH)))
      else $error("full status with queue not full");

   // After a successful enqueue the queue holds at least one entry.
   a_enq_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && status == ST_ENQUEUED) |-> (occupancy != '0))
      else $error("enqueue reported with empty queue");

   // After a returned entry the queue cannot be full.
   a_ret_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && status == ST_RETURNED) |-> (occupancy != OCC_W'(QUEUE_DEPTH)))
      else $error("entry returned but queue still full");

endmodule

bind stable_priority_queue_top spq_checker u_spq_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .status         (rsp_chan.status),
   .out_priority   (rsp_chan.out_priority),
   .out_depth      (rsp_chan.out_depth),
   .out_item_tag   (rsp_chan.out_item_tag),
   .out_parent_tag (rsp_chan.out_parent_tag),
   .occupancy      (rsp_chan.occupancy)
);

`default_nettype wire

@@ tb/stable_priority_queue_top_tb.sv @@
// Self-checking testbench for stable_priority_queue_top: a directed table, then
// random enqueue/dequeue traffic with idling and back-pressure on both channels.
// Depends on spq_pkg, spq_if and the RTL of the block; nothing else.
`default_nettype none

module stable_priority_queue_top_tb;
   import spq_pkg::*;

   localparam int PHASE_ITEMS = 550;
   localparam int SEGMENT_LEN = 100;
   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 8;

   // One request beat as the sender sees it.
   typedef struct packed {
      logic                     command;
      logic signed [PRIO_W-1:0] prio;
      logic [DEPTH_W-1:0]       depth;
      logic [TAG_W-1:0]         item;
      logic [TAG_W-1:0]         parent;
      logic                     halt;
   } request_type;

   // One response beat as the receiver expects it.
   typedef struct packed {
      spq_status_type           status;
      logic signed [PRIO_W-1:0] prio;
      logic [DEPTH_W-1:0]       depth;
      logic [TAG_W-1:0]         item;
      logic [TAG_W-1:0]         parent;
      logic [OCC_W-1:0]         occupancy;
   } response_type;

   // A row of the directed table; typed rows carry their own expected beat.
   typedef struct packed {
      request_type  req;
      logic         typed;
      response_type want;
   } table_row_type;

   localparam response_type NOT_TYPED =
      '{ST_ENQUEUED, 16'sh0000, 8'h00, 16'h0000, 16'h0000, 7'd0};

   localparam int TABLE_LEN = 20;
   localparam table_row_type DIRECTED_TABLE [TABLE_LEN] = '{
      // Dequeue from an empty queue, with and without halt.
      '{'{CMD_DEQUEUE, 16'sh0000, 8'h00, 16'h0000, 16'h0000, 1'b0}, 1'b1,
        '{ST_NO_ENTRY, 16'sh0000, 8'h00, 16'h0000, 16'h0000, 7'd0}},
      '{'{CMD_DEQUEUE, 16'sh0000, 8'h00, 16'h0000, 16'h0000, 1'b1}, 1'b1,
        '{ST_NO_ENTRY, 16'sh0000, 8'h00, 16'h0000, 16'h0000, 7'd0}},
      // Extremes; halt is ignored by an enqueue.
      '{'{CMD_ENQUEUE, 16'sh7FFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1}, 1'b1,
        '{ST_ENQUEUED, 16'sh0000, 8'h00, 16'h0000, 16'h0000, 7'd1}},
      '{'{CMD_ENQUEUE, 16'sh8000, 8'h00, 16'h0000, 16'h0000, 1'b0}, 1'b1,
        '{ST_ENQUEUED, 16'sh0000, 8'h00, 16'h0000, 16'h0000, 7'd2}},
      // Two equal priorities must leave in arrival order.
      '{'{CMD_ENQUEUE, 16'sh0000, 8'h01, 16'h0001, 16'h0100, 1'b0}, 1'b1,
        '{ST_ENQUEUED, 16'sh0000, 8'h00, 16'h0000, 16'h0000, 7'd3}},
      '{'{CMD_ENQUEUE, 16'sh0000, 8'h02, 16'h0002, 16'h0200, 1'b0}, 1'b1,
        '{ST_ENQUEUED, 16'sh0000, 8'h00, 16'h0000, 16'h0000, 7'd4}},
      '{'{CMD_ENQUEUE, 16'shFFFF, 8'h03, 16'h0003, 16'h0300, 1'b0}, 1'b0, NOT_TYPED},
      '{'{CMD_ENQUEUE, 16'sh0001, 8'h04, 16'h0004, 16'h0400, 1'b0}, 1'b0, NOT_TYPED},
      // Halted dequeue leaves a non-empty queue untouched.
      '{'{CMD_DEQUEUE, 16'sh0000, 8'h00, 16'h0000, 16'h0000, 1'b1}, 1'b1,
        '{ST_NO_ENTRY, 16'sh0000, 8'h00, 16'h0000, 16'h0000, 7'd6}},
      '{'{CMD_DEQUEUE, 16'sh0000, 8'h00, 16'h0000, 16'h0000, 1'b0}, 1'b1,
        '{ST_RETURNED, 16'sh7FFF, 8'hFF, 16'hFFFF, 16'hFFFF, 7'd5}},
      '{'{CMD_DEQUEUE, 16'sh0000, 8'h00, 16'h0000, 16'h0000, 1'b0}, 1'b0, NOT_TYPED},
      '{'{CMD_DEQUEUE, 16'sh0000, 8'h00, 16'h0000, 16'h0000, 1'b0}, 1'b0, NOT_TYPED},
      '{'{CMD_DEQUEUE, 16'sh0000, 8'h00, 16'h0000, 16'h0000, 1'b0}, 1'b0, NOT_TYPED},
      '{'{CMD_DEQUEUE, 16'sh0000, 8'h00, 16'h0000, 16'h0000, 1'b0}, 1'b0, NOT_TYPED},
      '{'{CMD_DEQUEUE, 16'sh0000, 8'h00, 16'h0000, 16'h0000, 1'b0}, 1'b1,
        '{ST_RETURNED, 16'sh8000, 8'h00, 16'h0000, 16'h0000, 7'd0}},
      '{'{CMD_DEQUEUE, 16'sh0000, 8'h00, 16'h0000, 16'h0000, 1'b0}, 1'b1,
        '{ST_NO_ENTRY, 16'sh0000, 8'h00, 16'h0000, 16'h0000, 7'd0}},
      // Alternating bit patterns on every field.
      '{'{CMD_ENQUEUE, 16'sh5555, 8'hAA, 16'hAAAA, 16'h5555, 1'b0}, 1'b1,
        '{ST_ENQUEUED, 16'sh0000, 8'h00, 16'h0000, 16'h0000, 7'd1}},
      '{'{CMD_ENQUEUE, 16'shAAAA, 8'h55, 16'h5555, 16'hAAAA, 1'b1}, 1'b1,
        '{ST_ENQUEUED, 16'sh0000, 8'h00, 16'h0000, 16'h0000, 7'd2}},
      '{'{CMD_DEQUEUE, 16'sh0000, 8'h00, 16'h0000, 16'h0000, 1'b0}, 1'b1,
        '{ST_RETURNED, 16'sh5555, 8'hAA, 16'hAAAA, 16'h5555, 7'd1}},
      '{'{CMD_DEQUEUE, 16'sh0000, 8'h00, 16'h0000, 16'h0000, 1'b0}, 1'b1,
        '{ST_RETURNED, 16'shAAAA, 8'h55, 16'h5555, 16'hAAAA, 7'd0}}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   spq_req_if req_bus();
   spq_rsp_if rsp_bus();

   stable_priority_queue_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Shadow copy of the queue contents, head first, and the beats still owed.
   spq_entry_type queued_entries[$];
   response_type  owed_responses[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_requests = 0;
   int error_count   = 0;
   int cycle_count   = 0;
   int enqueued_seen = 0;
   int returned_seen = 0;
   int no_entry_seen = 0;
   int dropped_seen  = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Apply one accepted request to the shadow queue and return the beat it owes.
   function automatic response_type apply_request(input request_type r);
      response_type  resp;
      spq_entry_type e;
      int            pos;
      resp = NOT_TYPED;
      if (r.command == CMD_ENQUEUE) begin
         if (queued_entries.size() >= QUEUE_DEPTH) begin
            resp.status = ST_FULL;
         end else begin
            e.prio   = r.prio;
            e.depth  = r.depth;
            e.item   = r.item;
            e.parent = r.parent;
            pos = 0;
            // The new entry goes behind every entry of equal or higher priority.
            while (pos < queued_entries.size() && queued_entries[pos].prio >= e.prio)
               pos++;
            queued_entries.insert(pos, e);
            resp.status = ST_ENQUEUED;
         end
      end else if (r.halt || queued_entries.size() == 0) begin
         resp.status = ST_NO_ENTRY;
      end else begin
         e = queued_entries.pop_front();
         resp.status = ST_RETURNED;
         resp.prio   = e.prio;
         resp.depth  = e.depth;
         resp.item   = e.item;
         resp.parent = e.parent;
      end
      resp.occupancy = OCC_W'(queued_entries.size());
      return resp;
   endfunction

   // Random request: enq_pct sets the mix, priorities cluster to force ties.
   function automatic request_type random_request(input int enq_pct);
      request_type r;
      r.command = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQUEUE : CMD_DEQUEUE;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: r.prio = PRIO_W'($urandom_range(0, 4)) - 16'sd2;
         4: begin
            case ($urandom_range(0, 3))
               0: r.prio = 16'sh8000;
               1: r.prio = 16'sh7FFF;
               2: r.prio = 16'shFFFF;
               default: r.prio = 16'sh0000;
            endcase
         end
         default: r.prio = PRIO_W'($urandom);
      endcase
      r.depth  = DEPTH_W'($urandom);
      r.item   = TAG_W'($urandom);
      r.parent = TAG_W'($urandom);
      // Halt is mostly low on dequeues so the queue actually drains.
      if (r.command == CMD_DEQUEUE)
         r.halt = ($urandom_range(0, 9) == 0);
      else
         r.halt = 1'($urandom_range(0, 1));
      return r;
   endfunction

   // Offer one request beat after a random gap and record what it owes.
   task automatic send_request(input request_type r, input logic typed,
                               input response_type want);
      response_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.command      <= r.command;
      req_bus.priority_req <= r.prio;
      req_bus.crawl_depth  <= r.depth;
      req_bus.item_tag     <= r.item;
      req_bus.parent_tag   <= r.parent;
      req_bus.halt         <= r.halt;
      req_bus.valid        <= 1'b1;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      predicted = apply_request(r);
      owed_responses.push_back(typed ? want : predicted);
   endtask

   // Receiver: random ready, long hold-offs on request, and the field checks.
   initial begin
      int           hold_left;
      int           holds_served;
      response_type want;
      hold_left    = 0;
      holds_served = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (owed_responses.size() == 0) begin
               $error("response beat with nothing owed: status %0d", rsp_bus.status);
               error_count++;
            end else begin
               want = owed_responses.pop_front();
               if (rsp_bus.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
                  error_count++;
               end
               if (rsp_bus.out_priority !== want.prio) begin
                  $error("out_priority: expected %0d, got %0d", want.prio,
                         rsp_bus.out_priority);
                  error_count++;
               end
               if (rsp_bus.out_depth !== want.depth) begin
                  $error("out_depth: expected %0d, got %0d", want.depth, rsp_bus.out_depth);
                  error_count++;
               end
               if (rsp_bus.out_item_tag !== want.item) begin
                  $error("out_item_tag: expected %h, got %h", want.item,
                         rsp_bus.out_item_tag);
                  error_count++;
               end
               if (rsp_bus.out_parent_tag !== want.parent) begin
                  $error("out_parent_tag: expected %h, got %h", want.parent,
                         rsp_bus.out_parent_tag);
                  error_count++;
               end
               if (rsp_bus.occupancy !== want.occupancy) begin
                  $error("occupancy: expected %0d, got %0d", want.occupancy,
                         rsp_bus.occupancy);
                  error_count++;
               end
               case (want.status)
                  ST_ENQUEUED: enqueued_seen++;
                  ST_RETURNED: returned_seen++;
                  ST_NO_ENTRY: no_entry_seen++;
                  default:     dropped_seen++;
               endcase
            end
         end
         // A new hold-off request starts a long stretch with ready low.
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Stimulus: reset, directed table, then three phases of random traffic, the last with no idling.
   initial begin
      int phase;
      int n;
      int enq_pct;
      req_bus.valid        = 1'b0;
      req_bus.command      = CMD_ENQUEUE;
      req_bus.priority_req = '0;
      req_bus.crawl_depth  = '0;
      req_bus.item_tag     = '0;
      req_bus.parent_tag   = '0;
      req_bus.halt         = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (n = 0; n < TABLE_LEN; n++)
         send_request(DIRECTED_TABLE[n].req, DIRECTED_TABLE[n].typed, DIRECTED_TABLE[n].want);

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 16;
               recv_idle_pct = 78;
            end
            1: begin
               send_idle_pct = 78;
               recv_idle_pct = 16;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (n = 0; n < PHASE_ITEMS; n++) begin
            // Receiver stalls for a long while; the sender keeps pushing.
            if (n == 120)
               hold_requests++;
            // Sender pauses until the queue's response side has caught up.
            if (n == 330) begin
               req_bus.valid <= 1'b0;
               do @(posedge clock); while (owed_responses.size() != 0);
            end
            // Segments alternate fill-to-full, drain-to-empty and a balanced mix.
            case ((n / SEGMENT_LEN) % 3)
               0:       enq_pct = 88;
               1:       enq_pct = 12;
               default: enq_pct = 50;
            endcase
            send_request(random_request(enq_pct), 1'b0, NOT_TYPED);
         end
      end

      // Let every owed beat arrive, then keep watching for stray beats.
      req_bus.valid <= 1'b0;
      recv_idle_pct = 0;
      do @(posedge clock); while (owed_responses.size() != 0);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Run covered %0d enqueues, %0d entries returned, %0d empty or halted",
               enqueued_seen, returned_seen, no_entry_seen);
      $display("dequeues and %0d enqueues dropped on a full queue, in %0d cycles.",
               dropped_seen, cycle_count);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
